@@ hdl/cfc_pkg.sv @@
package cfc_pkg;

   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned CsrIndexWidth = 8;
   localparam int unsigned CrcWidth      = 32;
   localparam int unsigned TailDepth     = 4;
   localparam int unsigned SeenWidth     = 3;

   localparam logic [CrcWidth-1:0] CrcPoly = 32'hEDB8_8320;
   localparam logic [CrcWidth-1:0] CrcOnes = 32'hFFFF_FFFF;

   // saturation point of the byte counter: a full crc plus at least one payload byte
   localparam logic [SeenWidth-1:0] SeenMax  = 3'd5;
   localparam logic [SeenWidth-1:0] SeenFull = 3'd4;

   // register map
   localparam logic [CsrIndexWidth-1:0] CsrStartMarker = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CsrEndMarker   = 8'd1;

   localparam logic [ByteWidth-1:0] StartMarkerReset = 8'h02;
   localparam logic [ByteWidth-1:0] EndMarkerReset   = 8'h03;

   // status codes
   localparam logic [1:0] StatGood     = 2'd0;
   localparam logic [1:0] StatCrcError = 2'd1;
   localparam logic [1:0] StatTooShort = 2'd2;
   localparam logic [1:0] StatNoFrame  = 2'd3;

   typedef struct packed {
      logic [ByteWidth-1:0] start_marker;
      logic [ByteWidth-1:0] end_marker;
   } cfg_type;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'b001,
      PH_COLLECT = 3'b010,
      PH_CLOSED  = 3'b100
   } phase_type;

   // reflected crc-32, one byte folded in
   function automatic logic [CrcWidth-1:0] crc_feed(input logic [CrcWidth-1:0] c,
                                                   input logic [ByteWidth-1:0] b);
      logic [CrcWidth-1:0] r;
      r = c ^ {{(CrcWidth-ByteWidth){1'b0}}, b};
      for (int k = 0; k < ByteWidth; k++) begin
         r = r[0] ? (CrcPoly ^ (r >> 1)) : (r >> 1);
      end
      return r;
   endfunction

endpackage

@@ hdl/cfc_if.sv @@
interface cfc_req_if;
   logic                            valid;
   logic                            ready;
   logic [cfc_pkg::ByteWidth-1:0]   in_byte;
   logic                            buffer_end;

   modport source (output valid, output in_byte, output buffer_end, input ready);
   modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

interface cfc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [cfc_pkg::ByteWidth-1:0]   out_byte;
   logic                            is_status;
   logic [1:0]                      status;

   modport source (output valid, output out_byte, output is_status, output status,
                   input ready);
   modport sink   (input valid, input out_byte, input is_status, input status,
                   output ready);
endinterface

interface cfc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [cfc_pkg::CsrIndexWidth-1:0]  index;
   logic [cfc_pkg::ByteWidth-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/cfc_csr.sv @@
module cfc_csr (
   input  logic              clock,
   input  logic              reset,
   cfc_csr_if.sink           csr_chan,
   output cfc_pkg::cfg_type  cfg
);

   cfc_pkg::cfg_type cfg_ff;
   cfc_pkg::cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            cfc_pkg::CsrStartMarker: cfg_in.start_marker = csr_chan.data;
            cfc_pkg::CsrEndMarker:   cfg_in.end_marker   = csr_chan.data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker <= cfc_pkg::StartMarkerReset;
         cfg_ff.end_marker   <= cfc_pkg::EndMarkerReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/cfc_core.sv @@
module cfc_core (
   input  logic              clock,
   input  logic              reset,
   input  cfc_pkg::cfg_type  cfg,
   cfc_req_if.sink           req_chan,
   cfc_rsp_if.source         rsp_chan
);

   localparam int unsigned BW = cfc_pkg::ByteWidth;

   // input register
   logic          in_valid_ff, in_valid_in;
   logic [BW-1:0] in_byte_ff;
   logic          in_last_ff;

   // frame state
   cfc_pkg::phase_type              phase_ff, phase_in;
   logic [BW-1:0]                   tail_ff [cfc_pkg::TailDepth];
   logic [BW-1:0]                   tail_in [cfc_pkg::TailDepth];
   logic [cfc_pkg::SeenWidth-1:0]   seen_ff, seen_in;
   logic [cfc_pkg::CrcWidth-1:0]    crc_ff, crc_in;

   // result register
   logic          out_valid_ff, out_valid_in;
   logic [BW-1:0] out_byte_ff;
   logic          out_is_status_ff;
   logic [1:0]    out_status_ff;

   logic          advance;
   logic          has_result;
   logic [BW-1:0] res_byte;
   logic          res_is_status;
   logic [1:0]    res_status;
   logic          full;
   logic [cfc_pkg::CrcWidth-1:0] crc_field;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign full      = (seen_ff >= cfc_pkg::SeenFull);
   assign crc_field = {tail_ff[0], tail_ff[1], tail_ff[2], tail_ff[3]};

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      tail_in       = tail_ff;
      seen_in       = seen_ff;
      crc_in        = crc_ff;
      has_result    = 1'b0;
      res_byte      = '0;
      res_is_status = 1'b0;
      res_status    = cfc_pkg::StatGood;
      unique case (phase_ff)
         cfc_pkg::PH_HUNT: begin
            if (in_byte_ff == cfg.start_marker) begin
               for (int i = 0; i < cfc_pkg::TailDepth; i++) begin
                  tail_in[i] = '0;
               end
               seen_in  = '0;
               crc_in   = cfc_pkg::CrcOnes;
               phase_in = cfc_pkg::PH_COLLECT;
            end
            if (in_last_ff) begin
               phase_in      = cfc_pkg::PH_HUNT;
               has_result    = 1'b1;
               res_is_status = 1'b1;
               res_status    = cfc_pkg::StatNoFrame;
            end
         end
         cfc_pkg::PH_COLLECT: begin
            if (in_byte_ff == cfg.end_marker) begin
               has_result    = 1'b1;
               res_is_status = 1'b1;
               if (seen_ff < cfc_pkg::SeenMax) begin
                  res_status = cfc_pkg::StatTooShort;
               end else if (crc_field == (crc_ff ^ cfc_pkg::CrcOnes)) begin
                  res_status = cfc_pkg::StatGood;
               end else begin
                  res_status = cfc_pkg::StatCrcError;
               end
               phase_in = in_last_ff ? cfc_pkg::PH_HUNT : cfc_pkg::PH_CLOSED;
            end else begin
               for (int i = 0; i < cfc_pkg::TailDepth - 1; i++) begin
                  tail_in[i] = tail_ff[i+1];
               end
               tail_in[cfc_pkg::TailDepth-1] = in_byte_ff;
               if (seen_ff < cfc_pkg::SeenMax) begin
                  seen_in = seen_ff + 1'b1;
               end
               if (full) begin
                  crc_in = cfc_pkg::crc_feed(crc_ff, tail_ff[0]);
               end
               if (in_last_ff) begin
                  phase_in      = cfc_pkg::PH_HUNT;
                  has_result    = 1'b1;
                  res_is_status = 1'b1;
                  res_status    = cfc_pkg::StatNoFrame;
               end else if (full) begin
                  has_result = 1'b1;
                  res_byte   = tail_ff[0];
               end
            end
         end
         default: begin
            if (in_last_ff) begin
               phase_in = cfc_pkg::PH_HUNT;
            end
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = has_result;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= cfc_pkg::PH_HUNT;
         seen_ff      <= '0;
         crc_ff       <= cfc_pkg::CrcOnes;
         for (int i = 0; i < cfc_pkg::TailDepth; i++) begin
            tail_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            seen_ff  <= seen_in;
            crc_ff   <= crc_in;
            tail_ff  <= tail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.in_byte;
         in_last_ff <= req_chan.buffer_end;
      end
      if (advance && has_result) begin
         out_byte_ff      <= res_byte;
         out_is_status_ff <= res_is_status;
         out_status_ff    <= res_status;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_byte  = out_byte_ff;
   assign rsp_chan.is_status = out_is_status_ff;
   assign rsp_chan.status    = out_status_ff;

   a_status_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_is_status_ff) |-> (out_byte_ff == '0))
      else $error("status transaction carries a nonzero byte");

   a_payload_status_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_is_status_ff) |-> (out_status_ff == cfc_pkg::StatGood))
      else $error("payload transaction carries a nonzero status");

   a_seen_saturates: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= cfc_pkg::SeenMax)
      else $error("byte counter passed its saturation point");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input transaction dropped while stalled");

   a_payload_keeps_collecting: assert property (@(posedge clock) disable iff (reset)
      (advance && has_result && !res_is_status) |=> (phase_ff == cfc_pkg::PH_COLLECT))
      else $error("payload byte given outside a frame");

endmodule

@@ hdl/crc32_frame_checker.sv @@
// channel   dir  handshake        payload
// req_chan  in   valid / ready    in_byte[7:0], buffer_end
// rsp_chan  out  valid / ready    out_byte[7:0], is_status, status[1:0]
// csr_chan  in   valid / ready    index[7:0], data[7:0]  (always ready)
//
// one byte per cycle sustained while rsp_chan is not stalled; a byte is held in the input
// register and its result is registered in the result register, which drives rsp_chan
// synchronous active-high reset: back to hunting, markers to 0x02 / 0x03
// a stalled rsp_chan holds its transaction and the input register stops advancing,
// even for a byte that gives no result; req_chan ready drops once that register is full
module crc32_frame_checker (
   input  logic        clock,
   input  logic        reset,
   cfc_req_if.sink     req_chan,
   cfc_rsp_if.source   rsp_chan,
   cfc_csr_if.sink     csr_chan
);

   // marker registers, handed to the core as one struct
   cfc_pkg::cfg_type cfg;

   // register file for the two markers
   cfc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // input register, frame hunt, delay line, crc and result register
   cfc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
